### rtl/thick_line_rasterizer_macros.svh
// Assertion macros shared by the thick line rasterizer RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef THICK_LINE_RASTERIZER_MACROS_SVH
`define THICK_LINE_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### rtl/tlr_pkg.sv
// Shared constants and request/point types for the thick line rasterizer.
// No dependencies; imported by tlr_stepper and thick_line_rasterizer.
package tlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int WIDTH_BITS = 4;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int OFS_BITS   = WIDTH_BITS + 1;
  localparam int PX_BITS    = COORD_BITS + 1;

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + WIDTH_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = PX_BITS + COORD_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef struct packed {
    logic                         func;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [WIDTH_BITS-1:0]        half_width;
  } tlr_item_t;

  typedef struct packed {
    logic signed [PX_BITS-1:0]    point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         pass_last;
    logic                         line_last;
  } tlr_point_t;

endpackage

### rtl/thick_line_rasterizer.sv
// Top level of the thick line rasterizer: request register, stepper, point register.
// Depends on tlr_pkg, tlr_stepper and thick_line_rasterizer_macros.svh.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata: start_x, start_y, end_x, end_y, half_width; tuser: func
//  m_axis   out        tdata: point_x, point_y; tlast: pass_last; tuser: line_last
//
// Each request passes through the stepper; one request per clock is accepted unless the output stalls.
// A request's point reaches the output through the request register, then the point register.
// The stepper advances whenever the point register is empty or being drained.
// A load request emits no point; a step request while idle emits none either.
// rst is synchronous and active high and leaves the rasterizer idle.
`include "thick_line_rasterizer_macros.svh"

module thick_line_rasterizer
  import tlr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // start_x, start_y, end_x, end_y, half_width from bit 0 up, zero padded
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // func
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // point_x, point_y from bit 0 up, zero padded
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  // line_last
  output logic                      m_axis_tuser
);

  tlr_item_t  item;
  tlr_point_t point, point_q;
  logic       item_valid, res_valid, advance, go, emit;

  assign advance       = !res_valid || m_axis_tready;
  assign go            = item_valid && advance;
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.func       <= s_axis_tuser;
      item.start_x    <= s_axis_tdata[COORD_BITS-1:0];
      item.start_y    <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      item.end_x      <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
      item.end_y      <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
      item.half_width <= s_axis_tdata[IN_FIELD_BITS-1:4*COORD_BITS];
    end
  end

  tlr_stepper u_stepper (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .item  (item),
    .emit  (emit),
    .point (point)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      point_q <= point;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {(OUT_TDATA_BITS - OUT_FIELD_BITS)'(0), point_q.point_y,
                          point_q.point_x};
  assign m_axis_tlast  = point_q.pass_last;
  assign m_axis_tuser  = point_q.line_last;

  `TLR_ASSERT_SAME(a_line_ends_pass, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `TLR_ASSERT_NEXT(a_idle_step_silent, clk, rst, go && !emit, !m_axis_tvalid)

endmodule

### rtl/tlr_stepper.sv
// Bresenham stepper state and its registered update for the thick line rasterizer.
// Depends on tlr_pkg and thick_line_rasterizer_macros.svh.
`include "thick_line_rasterizer_macros.svh"

module tlr_stepper
  import tlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  tlr_item_t  item,
  output logic       emit,
  output tlr_point_t point
);

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] nd;
    d  = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    nd = (COORD_BITS + 1)'(0) - d;
    abs_diff = d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  logic signed [COORD_BITS-1:0] walk_x, walk_y, origin_x, origin_y, target_x, target_y;
  logic [COORD_BITS-1:0]        dist_x, dist_y;
  logic                         back_x, back_y;
  logic signed [ERR_BITS-1:0]   error_term;
  logic signed [OFS_BITS-1:0]   pass_offset;
  logic [WIDTH_BITS-1:0]        width_limit;
  logic                         busy;

  logic [COORD_BITS-1:0]        load_dx, load_dy;
  logic signed [ERR_BITS-1:0]   load_err, pass_err;
  logic                         at_end, last_pass, move_x, move_y;
  logic signed [ERR_BITS:0]     e2, neg_dy, pos_dx;
  logic signed [ERR_BITS-1:0]   err_step;

  assign load_dx  = abs_diff(item.end_x, item.start_x);
  assign load_dy  = abs_diff(item.end_y, item.start_y);
  assign load_err = $signed({2'b00, load_dx}) - $signed({2'b00, load_dy});
  assign pass_err = $signed({2'b00, dist_x}) - $signed({2'b00, dist_y});

  assign at_end    = (walk_x == target_x) && (walk_y == target_y);
  assign last_pass = (pass_offset == $signed({1'b0, width_limit}));

  assign e2     = $signed({error_term, 1'b0});
  assign pos_dx = $signed({3'b000, dist_x});
  assign neg_dy = $signed((ERR_BITS + 1)'(0) - {3'b000, dist_y});
  assign move_x = e2 > neg_dy;
  assign move_y = e2 < pos_dx;

  always_comb begin
    err_step = error_term;
    if (move_x) begin
      err_step = err_step - $signed({2'b00, dist_y});
    end
    if (move_y) begin
      err_step = err_step + $signed({2'b00, dist_x});
    end
  end

  assign emit            = (item.func == FUNC_STEP) && busy;
  assign point.point_x   = $signed({walk_x[COORD_BITS-1], walk_x})
                         + $signed({{(PX_BITS - OFS_BITS){pass_offset[OFS_BITS-1]}},
                                    pass_offset});
  assign point.point_y   = walk_y;
  assign point.pass_last = at_end;
  assign point.line_last = at_end && last_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      if (item.func == FUNC_LOAD) begin
        busy <= 1'b1;
      end else if (busy && at_end && last_pass) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (item.func == FUNC_LOAD) begin
        origin_x    <= item.start_x;
        origin_y    <= item.start_y;
        target_x    <= item.end_x;
        target_y    <= item.end_y;
        walk_x      <= item.start_x;
        walk_y      <= item.start_y;
        dist_x      <= load_dx;
        dist_y      <= load_dy;
        back_x      <= !(item.start_x < item.end_x);
        back_y      <= !(item.start_y < item.end_y);
        error_term  <= load_err;
        width_limit <= item.half_width;
        pass_offset <= $signed(OFS_BITS'(0) - {1'b0, item.half_width});
      end else if (busy) begin
        if (at_end) begin
          // A pass has reached the far endpoint: unless it was the last, rerun the line one column over.
          if (!last_pass) begin
            pass_offset <= pass_offset + $signed(OFS_BITS'(1));
            walk_x      <= origin_x;
            walk_y      <= origin_y;
            error_term  <= pass_err;
          end
        end else begin
          error_term <= err_step;
          if (move_x) begin
            walk_x <= back_x ? walk_x - $signed(COORD_BITS'(1))
                             : walk_x + $signed(COORD_BITS'(1));
          end
          if (move_y) begin
            walk_y <= back_y ? walk_y - $signed(COORD_BITS'(1))
                             : walk_y + $signed(COORD_BITS'(1));
          end
        end
      end
    end
  end

  `TLR_ASSERT_SAME(a_offset_in_range, clk, rst, busy, pass_offset <= $signed({1'b0, width_limit}))
  `TLR_ASSERT_NEXT(a_load_arms, clk, rst, go && (item.func == FUNC_LOAD), busy)
  `TLR_ASSERT_NEXT(a_line_end_idles, clk, rst, go && emit && point.line_last, !busy)

endmodule

### test/tlr_point_checker.sv
// Point checker for the thick line rasterizer: follows both streams and predicts every point.
// Depends on tlr_pkg for the request and point types; instantiated by tb_thick_line_rasterizer.
`timescale 1ns / 1ps

module tlr_point_checker
  import tlr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  // start_x, start_y, end_x, end_y, half_width from bit 0 up, zero padded
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // func
  input  logic                      s_axis_tuser,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // point_x, point_y from bit 0 up, zero padded
  input  logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input  logic                      m_axis_tlast,
  // line_last
  input  logic                      m_axis_tuser,
  output int                        fail_count,
  output int                        pending
);

  logic signed [COORD_BITS-1:0] walk_x, walk_y, origin_x, origin_y, target_x, target_y;
  logic signed [ERR_BITS-1:0]   error_term;
  logic signed [OFS_BITS-1:0]   pass_offset;
  logic [WIDTH_BITS-1:0]        width_limit;
  logic                         busy;

  tlr_point_t expected_points[$];
  int         mismatches;

  function automatic int span(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic restart_pass();
    walk_x     = origin_x;
    walk_y     = origin_y;
    error_term = ERR_BITS'(span(target_x, origin_x) - span(target_y, origin_y));
  endtask

  // Applies one accepted request to the shadow stepper and queues the point it causes.
  task automatic advance_line(input tlr_item_t req);
    int         dx, dy, sx, sy, e2;
    logic       at_end;
    tlr_point_t pt;
    if (req.func == FUNC_LOAD) begin
      origin_x    = req.start_x;
      origin_y    = req.start_y;
      target_x    = req.end_x;
      target_y    = req.end_y;
      width_limit = req.half_width;
      pass_offset = OFS_BITS'(-int'(req.half_width));
      restart_pass();
      busy = 1'b1;
    end else if (busy) begin
      at_end       = (walk_x == target_x) && (walk_y == target_y);
      pt.point_x   = PX_BITS'(int'(walk_x) + int'(pass_offset));
      pt.point_y   = walk_y;
      pt.pass_last = at_end;
      pt.line_last = at_end && (int'(pass_offset) == int'(width_limit));
      expected_points.push_back(pt);
      if (at_end) begin
        if (pt.line_last) begin
          busy = 1'b0;
        end else begin
          pass_offset = OFS_BITS'(int'(pass_offset) + 1);
          restart_pass();
        end
      end else begin
        dx = span(target_x, origin_x);
        dy = span(target_y, origin_y);
        sx = (origin_x < target_x) ? 1 : -1;
        sy = (origin_y < target_y) ? 1 : -1;
        // Both tests use the error as it stood before this step.
        e2 = 2 * int'(error_term);
        if (e2 > -dy) begin
          error_term = ERR_BITS'(int'(error_term) - dy);
          walk_x     = COORD_BITS'(int'(walk_x) + sx);
        end
        if (e2 < dx) begin
          error_term = ERR_BITS'(int'(error_term) + dx);
          walk_y     = COORD_BITS'(int'(walk_y) + sy);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    tlr_item_t  req;
    tlr_point_t got, want;
    if (rst) begin
      walk_x = '0; walk_y = '0; origin_x = '0; origin_y = '0;
      target_x = '0; target_y = '0; error_term = '0;
      pass_offset = '0; width_limit = '0; busy = 1'b0;
      expected_points.delete();
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.point_x   = m_axis_tdata[0 +: PX_BITS];
        got.point_y   = m_axis_tdata[PX_BITS +: COORD_BITS];
        got.pass_last = m_axis_tlast;
        got.line_last = m_axis_tuser;
        if (expected_points.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected point, expected none, got x %0d y %0d pass %0b line %0b",
                   $time, got.point_x, got.point_y, got.pass_last, got.line_last);
        end else begin
          want = expected_points.pop_front();
          if (got.point_x !== want.point_x) begin
            mismatches++;
            $display("%0t: point_x expected %0d got %0d", $time, want.point_x, got.point_x);
          end
          if (got.point_y !== want.point_y) begin
            mismatches++;
            $display("%0t: point_y expected %0d got %0d", $time, want.point_y, got.point_y);
          end
          if (got.pass_last !== want.pass_last) begin
            mismatches++;
            $display("%0t: pass_last expected %0b got %0b", $time, want.pass_last,
                     got.pass_last);
          end
          if (got.line_last !== want.line_last) begin
            mismatches++;
            $display("%0t: line_last expected %0b got %0b", $time, want.line_last,
                     got.line_last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.func       = s_axis_tuser;
        req.start_x    = s_axis_tdata[0 +: COORD_BITS];
        req.start_y    = s_axis_tdata[COORD_BITS +: COORD_BITS];
        req.end_x      = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
        req.end_y      = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
        req.half_width = s_axis_tdata[4*COORD_BITS +: WIDTH_BITS];
        advance_line(req);
      end
    end
    fail_count <= mismatches;
    pending    <= expected_points.size();
  end

endmodule

### test/tb_thick_line_rasterizer.sv
// Testbench top for the thick line rasterizer: clock, reset, request and point traffic, verdict.
// Depends on tlr_pkg, thick_line_rasterizer and tlr_point_checker.
`timescale 1ns / 1ps

module tb_thick_line_rasterizer;
  import tlr_pkg::*;

  localparam int LINE_ITEMS     = 1650;
  localparam int STALL_LIMIT    = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int LATENCY_CYCLES = 8;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
  logic                      s_axis_tuser = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      m_axis_tuser;

  int fail_count;
  int pending;
  int sent_items = 0;
  int tx_count   = 0;
  bit tx_calm    = 1'b0;

  thick_line_rasterizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  tlr_point_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_request(input logic func, input int sx, input int sy,
                              input int ex, input int ey, input int hw);
    logic [IN_TDATA_BITS-1:0] word;
    int                       gap;
    word = '0;
    word[0 +: COORD_BITS]            = sx[COORD_BITS-1:0];
    word[COORD_BITS +: COORD_BITS]   = sy[COORD_BITS-1:0];
    word[2*COORD_BITS +: COORD_BITS] = ex[COORD_BITS-1:0];
    word[3*COORD_BITS +: COORD_BITS] = ey[COORD_BITS-1:0];
    word[4*COORD_BITS +: WIDTH_BITS] = hw[WIDTH_BITS-1:0];
    if (tx_count % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    tx_count++;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= word;
    s_axis_tuser  <= func;
    s_axis_tvalid <= 1'b1;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // The endpoint fields of a step request are ignored, so they carry noise.
  task automatic send_step();
    send_request(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  // One load followed by steps: mostly a whole short line, sometimes cut off by the next load.
  task automatic random_line();
    int sx, sy, ex, ey, hw, reach, kind, len_x, len_y, pts, n, pick;
    kind = $urandom_range(0, 99);
    sx   = int'($urandom_range(0, 4095)) - 2048;
    sy   = int'($urandom_range(0, 4095)) - 2048;
    pick = $urandom_range(0, 9);
    if (pick < 7) hw = $urandom_range(0, 3);
    else if (pick < 9) hw = $urandom_range(4, 8);
    else hw = $urandom_range(9, 15);
    if (kind < 85) begin
      reach = (hw >= 9) ? 3 : (($urandom_range(0, 9) == 0) ? 40 : 8);
      ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
      ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
    end else begin
      ex = int'($urandom_range(0, 4095)) - 2048;
      ey = int'($urandom_range(0, 4095)) - 2048;
    end
    len_x = (ex > sx) ? ex - sx : sx - ex;
    len_y = (ey > sy) ? ey - sy : sy - ey;
    pts   = (2 * hw + 1) * (((len_x > len_y) ? len_x : len_y) + 1);
    if (kind < 85 && pts <= 400)
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, pts - 1) : pts;
    else
      n = $urandom_range(0, 30);
    send_request(FUNC_LOAD, sx, sy, ex, ey, hw);
    repeat (n) send_step();
    sent_items += 1 + n;
    // Steps after the end of a line find the stepper idle.
    if (n == pts) repeat ($urandom_range(0, 2)) send_step();
  endtask

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_step();
    // Opposite corners, left unfinished by the next load.
    send_request(FUNC_LOAD, -2048, -2048, 2047, 2047, 0);
    repeat (3) send_step();
    send_request(FUNC_LOAD, 2047, 2047, -2048, -2048, 15);
    repeat (2) send_step();
    send_request(FUNC_LOAD, -2048, 2047, -2048, 2047, 15);
    send_step();
    // A single-pixel line at the far edge runs through every pass.
    send_request(FUNC_LOAD, 2047, -2048, 2047, -2048, 15);
    repeat (31) send_step();
    send_step();
    send_request(FUNC_LOAD, 3, -1, 2, 4, 0);
    repeat (6) send_step();
    send_step();

    while (sent_items < LINE_ITEMS) begin
      if (!paused && sent_items >= LINE_ITEMS / 2) begin
        paused = 1'b1;
        drain_points();
      end
      random_line();
    end
    drain_points();
    repeat (LATENCY_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** thick_line_rasterizer: PASSED **");
    end else begin
      $display("** thick_line_rasterizer: FAILED **");
    end
    $finish;
  end

  initial begin : receiver
    int gap, taken;
    bit rx_calm;
    taken   = 0;
    rx_calm = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 8);
      // Twice in the run the output is held off long enough to back up the input.
      if (taken == 200 || taken == 700) gap = LONG_HOLD;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk);
      while (!m_axis_tvalid) @(negedge clk);
      @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("** thick_line_rasterizer: FAILED **");
        $finish;
      end
    end
  end

endmodule
